[rtl/lps_pkg.sv]
package lps_pkg;

    localparam int PIX_ADDR_W     = 9;
    localparam int PIX_W          = 16;
    localparam int BYTE_W         = 8;
    localparam int NUM_BANKS      = 8;
    localparam int BANK_SEL_W     = 3;
    localparam int MAX_RUN        = 8;
    localparam int RUN_CNT_W      = 3;
    localparam int PLANE_W        = 3;
    localparam int ROW_SEL_W      = 3;
    localparam int DUR_W          = 16;
    localparam int NUM_PLANE_REGS = 5;
    localparam int CFG_INDEX_W    = 3;
    localparam int GREEN_BASE     = 6;
    localparam int BLUE_BASE      = 11;
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = 1;
    localparam int CMD_CNT_W      = 2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    typedef logic [DUR_W-1:0] plane_time_t;

    localparam plane_time_t PLANE_TIME_RESET [NUM_PLANE_REGS] = '{
        16'd500, 16'd1200, 16'd2500, 16'd6000, 16'd15000
    };

    typedef enum logic {
        CMD_WRITE,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [PIX_ADDR_W-1:0]   addr;
        logic [PIX_W-1:0]        value;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    typedef enum logic [1:0] {
        ST_FETCH,
        ST_ISSUE,
        ST_CAPTURE
    } scan_state_t;

endpackage

[rtl/lps_front.sv]
module lps_front import lps_pkg::*; #(
    parameter int DEPTH = 512
) (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [PIX_ADDR_W-1:0] s_pixel_addr,
    input  logic [PIX_W-1:0]      s_pixel_value,
    input  logic                  clr_busy,
    input  fifo_status_t          q_status,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic is_tick;
    logic addr_ok;
    logic accept;

    // Writes outside the frame store are taken from the channel and dropped here.
    assign is_tick = (s_func == FUNC_TICK);
    assign addr_ok = (32'(s_pixel_addr) < DEPTH);
    assign s_ready = !clr_busy && !q_status.full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (is_tick || addr_ok);

    always_comb begin
        q_cmd.kind  = is_tick ? CMD_TICK : CMD_WRITE;
        q_cmd.addr  = s_pixel_addr;
        q_cmd.value = s_pixel_value;
    end

endmodule

[rtl/lps_cmd_fifo.sv]
module lps_cmd_fifo import lps_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  cmd_t         push_cmd,
    input  logic         pop,
    output cmd_t         head,
    output fifo_status_t status
);

    cmd_t                 entry_reg [CMD_FIFO_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;

    always_comb begin
        status.empty = (count_reg == '0);
        status.full  = (count_reg == CMD_CNT_W'(CMD_FIFO_DEPTH));
        head         = entry_reg[rd_ptr_reg];
        wr_ptr_next  = push ? wr_ptr_reg + CMD_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next  = pop ? rd_ptr_reg + CMD_PTR_W'(1) : rd_ptr_reg;
        count_next   = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CMD_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/lps_frame_mem.sv]
module lps_frame_mem import lps_pkg::*; #(
    parameter int DEPTH = 512
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]                  wr_addr,
    input  logic [PIX_W-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [$clog2(DEPTH)-BANK_SEL_W-1:0]       rd_idx  [NUM_BANKS],
    output logic [PIX_W-1:0]                          rd_data [NUM_BANKS],
    output logic                                      clr_busy
);

    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int IDX_W      = ADDR_W - BANK_SEL_W;
    localparam int BANK_DEPTH = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;

    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;
    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [PIX_W-1:0] rdata_reg [NUM_BANKS];

    // Consecutive addresses fall in different banks, so one byte reads all banks at once.
    always_comb begin
        clr_idx_next  = clr_idx_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == IDX_W'(BANK_DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_idx_reg  <= clr_idx_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign clr_busy = clr_busy_reg;
    assign rd_data  = rdata_reg;

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        logic [PIX_W-1:0] bank_reg [BANK_DEPTH];

        always_ff @(posedge aclk) begin
            if (clr_busy_reg) begin
                bank_reg[clr_idx_reg] <= '0;
            end else if (wr_en && (wr_addr[BANK_SEL_W-1:0] == BANK_SEL_W'(g))) begin
                bank_reg[wr_addr[ADDR_W-1:BANK_SEL_W]] <= wr_data;
            end
            if (rd_en) begin
                rdata_reg[g] <= bank_reg[rd_idx[g]];
            end
        end
    end

endmodule

[rtl/lps_back.sv]
module lps_back import lps_pkg::*; #(
    parameter int COLUMNS   = 32,
    parameter int ROWS      = 16,
    parameter int SCAN_ROWS = 8,
    parameter int PLANES    = 5
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  fifo_status_t                                  q_status,
    input  cmd_t                                          q_head,
    output logic                                          q_pop,
    output logic                                          mem_wr_en,
    output logic [$clog2(COLUMNS*ROWS)-1:0]               mem_wr_addr,
    output logic [PIX_W-1:0]                              mem_wr_data,
    output logic                                          mem_rd_en,
    output logic [$clog2(COLUMNS*ROWS)-BANK_SEL_W-1:0]    mem_rd_idx  [NUM_BANKS],
    input  logic [PIX_W-1:0]                              mem_rd_data [NUM_BANKS],
    input  plane_time_t                                   plane_time  [NUM_PLANE_REGS],
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [BYTE_W-1:0]                             m_red_bits,
    output logic [BYTE_W-1:0]                             m_green_bits,
    output logic [BYTE_W-1:0]                             m_blue_bits,
    output logic [ROW_SEL_W-1:0]                          m_row_select,
    output logic [PLANE_W-1:0]                            m_plane_index,
    output logic                                          m_blank,
    output logic [DUR_W-1:0]                              m_duration,
    output logic                                          m_frame_done,
    output logic                                          m_last
);

    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = ADDR_W - BANK_SEL_W;
    localparam int PR_W   = $clog2(ROWS);
    localparam int RC_W   = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
    localparam int CB_W   = $clog2(COLUMNS);
    localparam int STEP_W = $clog2(ROWS + SCAN_ROWS + 1);

    scan_state_t          state_reg;
    scan_state_t          state_next;

    logic [PLANE_W-1:0]   plane_reg;
    logic [PLANE_W-1:0]   plane_next;
    logic [RC_W-1:0]      row_reg;
    logic [RC_W-1:0]      row_next;

    logic [PLANE_W-1:0]   tick_plane_reg;
    logic [RC_W-1:0]      tick_row_reg;
    logic [DUR_W-1:0]     tick_dur_reg;
    logic                 tick_done_reg;
    logic                 tick_done_next;

    logic [PR_W-1:0]      prow_reg;
    logic [PR_W-1:0]      prow_first_reg;
    logic [ADDR_W-1:0]    rowbase_reg;
    logic [ADDR_W-1:0]    rowstart_reg;
    logic [CB_W-1:0]      colbase_reg;
    logic [RUN_CNT_W-1:0] k_reg;
    logic                 byte_last_reg;
    logic                 byte_last_next;
    logic [2:0]           top_lo_reg;
    logic [BYTE_W-1:0]    bit_ok_reg;
    logic [BYTE_W-1:0]    bit_ok_next;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_red_reg;
    logic [BYTE_W-1:0]    out_green_reg;
    logic [BYTE_W-1:0]    out_blue_reg;
    logic [ROW_SEL_W-1:0] out_row_reg;
    logic [PLANE_W-1:0]   out_plane_reg;
    logic                 out_blank_reg;
    logic [DUR_W-1:0]     out_dur_reg;
    logic                 out_done_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 tick_load;
    logic                 out_load;
    logic                 tick_nonempty;
    logic                 plane_wrap;
    logic                 row_wrap;
    logic [31:0]          row_base32;
    logic [31:0]          wr_addr32;
    logic [31:0]          row32;

    logic [ADDR_W-1:0]    top;
    logic [IDX_W-1:0]     top_hi;
    logic [2:0]           top_lo;
    logic [STEP_W-1:0]    prow_sum;
    logic                 prow_wrap;
    logic [CB_W:0]        col_sum;
    logic                 col_end;

    logic [BYTE_W-1:0]    red_c;
    logic [BYTE_W-1:0]    green_c;
    logic [BYTE_W-1:0]    blue_c;

    assign out_free      = !out_valid_reg || m_ready;
    assign tick_nonempty = (row_reg < ROWS);
    assign plane_wrap    = ((32'(plane_reg) + 32'd1) >= PLANES);
    assign row_wrap      = ((32'(row_reg) + 32'd1) >= SCAN_ROWS);
    assign row_base32    = 32'(row_reg) * 32'(COLUMNS);
    assign wr_addr32     = 32'(q_head.addr);
    assign row32         = 32'(tick_row_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FETCH: begin
                if (!q_status.empty && (q_head.kind == CMD_TICK) && tick_nonempty) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (out_free) begin
                    state_next = ST_CAPTURE;
                end
            end
            ST_CAPTURE: begin
                state_next = byte_last_reg ? ST_FETCH : ST_ISSUE;
            end
            default: begin
                state_next = ST_FETCH;
            end
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        mem_wr_en = 1'b0;
        tick_load = 1'b0;
        mem_rd_en = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_FETCH: begin
                q_pop     = !q_status.empty;
                mem_wr_en = !q_status.empty && (q_head.kind == CMD_WRITE);
                tick_load = !q_status.empty && (q_head.kind == CMD_TICK);
            end
            ST_ISSUE: begin
                mem_rd_en = out_free;
            end
            ST_CAPTURE: begin
                out_load = 1'b1;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign mem_wr_addr = wr_addr32[ADDR_W-1:0];
    assign mem_wr_data = q_head.value;

    always_comb begin
        plane_next     = plane_reg;
        row_next       = row_reg;
        tick_done_next = 1'b0;
        if (plane_wrap) begin
            plane_next = '0;
            if (row_wrap) begin
                row_next       = '0;
                tick_done_next = 1'b1;
            end else begin
                row_next = row_reg + RC_W'(1);
            end
        end else begin
            plane_next = plane_reg + PLANE_W'(1);
        end
    end

    // The byte covers addresses top-7 .. top; bit b comes from address top-b.
    always_comb begin
        top    = rowbase_reg + ADDR_W'(COLUMNS - 1) - ADDR_W'(colbase_reg);
        top_hi = top[ADDR_W-1:BANK_SEL_W];
        top_lo = top[BANK_SEL_W-1:0];
        for (int j = 0; j < NUM_BANKS; j++) begin
            if ((3'(j) <= top_lo) || (top_hi == '0)) begin
                mem_rd_idx[j] = top_hi;
            end else begin
                mem_rd_idx[j] = top_hi - IDX_W'(1);
            end
        end
        for (int b = 0; b < BYTE_W; b++) begin
            bit_ok_next[b] = (top_hi != '0) || (top_lo >= 3'(b));
        end
        prow_sum       = STEP_W'(prow_reg) + STEP_W'(SCAN_ROWS);
        prow_wrap      = (prow_sum >= STEP_W'(ROWS));
        col_sum        = (CB_W + 1)'(colbase_reg) + (CB_W + 1)'(BYTE_W);
        col_end        = (col_sum >= (CB_W + 1)'(COLUMNS));
        byte_last_next = (k_reg == RUN_CNT_W'(MAX_RUN - 1)) || (prow_wrap && col_end);
    end

    always_comb begin
        logic [2:0]       bank;
        logic [PIX_W-1:0] px;
        bank = '0;
        px   = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            bank       = top_lo_reg - 3'(b);
            px         = mem_rd_data[bank];
            red_c[b]   = bit_ok_reg[b] & px[4'(tick_plane_reg)];
            green_c[b] = bit_ok_reg[b] & px[4'(tick_plane_reg) + 4'(GREEN_BASE)];
            blue_c[b]  = bit_ok_reg[b] & px[4'(tick_plane_reg) + 4'(BLUE_BASE)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FETCH;
            plane_reg     <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (tick_load) begin
                plane_reg <= plane_next;
                row_reg   <= row_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_load) begin
            tick_plane_reg <= plane_reg;
            tick_row_reg   <= row_reg;
            tick_dur_reg   <= plane_time[plane_reg];
            tick_done_reg  <= tick_done_next;
            prow_reg       <= PR_W'(row_reg);
            prow_first_reg <= PR_W'(row_reg);
            rowbase_reg    <= row_base32[ADDR_W-1:0];
            rowstart_reg   <= row_base32[ADDR_W-1:0];
            colbase_reg    <= '0;
            k_reg          <= '0;
        end
        if (mem_rd_en) begin
            top_lo_reg    <= top_lo;
            bit_ok_reg    <= bit_ok_next;
            byte_last_reg <= byte_last_next;
            k_reg         <= k_reg + RUN_CNT_W'(1);
            if (prow_wrap) begin
                prow_reg    <= prow_first_reg;
                rowbase_reg <= rowstart_reg;
                colbase_reg <= col_sum[CB_W-1:0];
            end else begin
                prow_reg    <= prow_sum[PR_W-1:0];
                rowbase_reg <= rowbase_reg + ADDR_W'(SCAN_ROWS * COLUMNS);
            end
        end
        if (out_load) begin
            out_red_reg   <= red_c;
            out_green_reg <= green_c;
            out_blue_reg  <= blue_c;
            out_row_reg   <= row32[ROW_SEL_W-1:0];
            out_plane_reg <= tick_plane_reg;
            out_blank_reg <= (tick_plane_reg == '0);
            out_dur_reg   <= tick_dur_reg;
            out_done_reg  <= tick_done_reg;
            out_last_reg  <= byte_last_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_red_bits    = out_red_reg;
    assign m_green_bits  = out_green_reg;
    assign m_blue_bits   = out_blue_reg;
    assign m_row_select  = out_row_reg;
    assign m_plane_index = out_plane_reg;
    assign m_blank       = out_blank_reg;
    assign m_duration    = out_dur_reg;
    assign m_frame_done  = out_done_reg;
    assign m_last        = out_last_reg;

endmodule

[rtl/led_panel_bit_plane_scanner.sv]
// Scan engine for a multiplexed RGB LED panel driven by binary code modulation.
// The input channel (s_) carries two kinds of transfer: a pixel write (s_func = 0)
// stores s_pixel_value at s_pixel_addr in the frame store, and a tick (s_func = 1)
// emits one bit plane of the current scan row as up to eight result transfers on
// the m_ channel, the final one flagged by m_last. Plane and row counters advance
// after every tick; m_frame_done marks the tick that finishes the last plane of
// the last scan row. Plane durations come from the cfg_ write port.
// Accepted items pass through a two-entry command queue into the scan sequencer,
// which handles them strictly in order. A write is handled in the fetch state. A
// tick is fetched, then runs an issue and a capture state for each byte: each
// byte reads eight pixels at once from an eight-bank frame store in the issue
// state and is packed in the capture state. The first byte of a tick passes
// through the queue, the fetch, issue and capture states and the result register.
// The result register holds a byte until it is taken; while m_ready is low the
// sequencer waits, the queue fills and s_ready drops.
// After reset the frame store is zeroed, one row of all banks per cycle, and
// s_ready stays low meanwhile.
// Configuration writes are taken at any time and should only occur while idle.
module led_panel_bit_plane_scanner import lps_pkg::*; #(
    parameter int COLUMNS   = 32,
    parameter int ROWS      = 16,
    parameter int SCAN_ROWS = 8,
    parameter int PLANES    = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_func,
    input  logic [PIX_ADDR_W-1:0]  s_pixel_addr,
    input  logic [PIX_W-1:0]       s_pixel_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [BYTE_W-1:0]      m_red_bits,
    output logic [BYTE_W-1:0]      m_green_bits,
    output logic [BYTE_W-1:0]      m_blue_bits,
    output logic [ROW_SEL_W-1:0]   m_row_select,
    output logic [PLANE_W-1:0]     m_plane_index,
    output logic                   m_blank,
    output logic [DUR_W-1:0]       m_duration,
    output logic                   m_frame_done,
    output logic                   m_last,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]       cfg_data
);

    localparam int DEPTH  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = ADDR_W - BANK_SEL_W;

    plane_time_t        plane_time_reg [NUM_PLANE_REGS];

    fifo_status_t       q_status;
    cmd_t               q_cmd;
    cmd_t               q_head;
    logic               q_push;
    logic               q_pop;
    logic               clr_busy;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [PIX_W-1:0]   mem_wr_data;
    logic               mem_rd_en;
    logic [IDX_W-1:0]   mem_rd_idx  [NUM_BANKS];
    logic [PIX_W-1:0]   mem_rd_data [NUM_BANKS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_time_reg <= PLANE_TIME_RESET;
        end else if (cfg_wen && (cfg_index < NUM_PLANE_REGS)) begin
            plane_time_reg[cfg_index] <= cfg_data;
        end
    end

    lps_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_pixel_addr  (s_pixel_addr),
        .s_pixel_value (s_pixel_value),
        .clr_busy      (clr_busy),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    lps_cmd_fifo u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    lps_frame_mem #(
        .DEPTH (DEPTH)
    ) u_frame_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd_en    (mem_rd_en),
        .rd_idx   (mem_rd_idx),
        .rd_data  (mem_rd_data),
        .clr_busy (clr_busy)
    );

    lps_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .SCAN_ROWS (SCAN_ROWS),
        .PLANES    (PLANES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_idx    (mem_rd_idx),
        .mem_rd_data   (mem_rd_data),
        .plane_time    (plane_time_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_bits    (m_red_bits),
        .m_green_bits  (m_green_bits),
        .m_blue_bits   (m_blue_bits),
        .m_row_select  (m_row_select),
        .m_plane_index (m_plane_index),
        .m_blank       (m_blank),
        .m_duration    (m_duration),
        .m_frame_done  (m_frame_done),
        .m_last        (m_last)
    );

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("Input transfer possible while the frame store is being cleared.");

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("Command pushed into a full queue.");

    a_frame_done_last_plane: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> (m_plane_index == PLANE_W'(PLANES - 1)))
        else $error("Frame done flagged on a plane other than the last one.");
`endif

endmodule

[tb/sv/scan_checker.sv]
`timescale 1ns / 1ps

module scan_checker import lps_pkg::*; #(
    parameter int COLUMNS   = 32,
    parameter int ROWS      = 16,
    parameter int SCAN_ROWS = 8,
    parameter int PLANES    = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_func,
    input  logic [PIX_ADDR_W-1:0]  s_pixel_addr,
    input  logic [PIX_W-1:0]       s_pixel_value,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [BYTE_W-1:0]      m_red_bits,
    input  logic [BYTE_W-1:0]      m_green_bits,
    input  logic [BYTE_W-1:0]      m_blue_bits,
    input  logic [ROW_SEL_W-1:0]   m_row_select,
    input  logic [PLANE_W-1:0]     m_plane_index,
    input  logic                   m_blank,
    input  logic [DUR_W-1:0]       m_duration,
    input  logic                   m_frame_done,
    input  logic                   m_last,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]       cfg_data,
    output int                     pending,
    output int                     errors
);

    localparam int STORE_DEPTH = COLUMNS * ROWS;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0]    red;
        logic [BYTE_W-1:0]    green;
        logic [BYTE_W-1:0]    blue;
        logic [ROW_SEL_W-1:0] row;
        logic [PLANE_W-1:0]   plane;
        logic                 blank;
        logic [DUR_W-1:0]     duration;
        logic                 frame_done;
        logic                 last;
    } scan_byte_t;

    logic [PIX_W-1:0]   pixels [STORE_DEPTH];
    logic [PLANE_W-1:0] plane_cnt;
    logic [ROW_SEL_W-1:0] row_cnt;
    plane_time_t        plane_time [NUM_PLANE_REGS];
    scan_byte_t         expected_bytes [$];
    int                 mismatches = 0;

    function automatic string describe(input scan_byte_t v);
        return $sformatf("r=%h g=%h b=%h row=%0d plane=%0d blank=%0b dur=%0d done=%0b last=%0b",
                         v.red, v.green, v.blue, v.row, v.plane, v.blank, v.duration,
                         v.frame_done, v.last);
    endfunction

    // Bit b of the byte holds the mirrored column COLUMNS-1-colbase-b.
    function automatic logic [BYTE_W-1:0] plane_byte(input int prow, input int colbase,
                                                     input int bitpos);
        logic [BYTE_W-1:0] acc;
        int addr;
        acc = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            addr = prow * COLUMNS + COLUMNS - 1 - colbase - b;
            if (addr >= 0 && addr < STORE_DEPTH) begin
                acc[b] = pixels[addr][bitpos % PIX_W];
            end
        end
        return acc;
    endfunction

    task automatic predict_tick();
        scan_byte_t run [MAX_RUN];
        int plane;
        int row;
        int count;
        logic [DUR_W-1:0] dur;
        logic done;
        plane = int'(plane_cnt);
        row = int'(row_cnt);
        dur = (plane < NUM_PLANE_REGS) ? plane_time[plane] : '0;
        done = 1'b0;
        if (plane + 1 >= PLANES) begin
            plane_cnt = '0;
            if (row + 1 >= SCAN_ROWS) begin
                row_cnt = '0;
                done = 1'b1;
            end else begin
                row_cnt = ROW_SEL_W'(row + 1);
            end
        end else begin
            plane_cnt = PLANE_W'(plane + 1);
        end
        count = 0;
        for (int colbase = 0; colbase < COLUMNS; colbase += 8) begin
            for (int prow = row; prow < ROWS; prow += SCAN_ROWS) begin
                if (count < MAX_RUN) begin
                    run[count].red = plane_byte(prow, colbase, plane);
                    run[count].green = plane_byte(prow, colbase, plane + GREEN_BASE);
                    run[count].blue = plane_byte(prow, colbase, plane + BLUE_BASE);
                    run[count].row = ROW_SEL_W'(row);
                    run[count].plane = PLANE_W'(plane);
                    run[count].blank = (plane == 0);
                    run[count].duration = dur;
                    run[count].frame_done = done;
                    run[count].last = 1'b0;
                    count++;
                end
            end
        end
        for (int k = 0; k < count; k++) begin
            run[k].last = (k + 1 == count);
            expected_bytes.push_back(run[k]);
        end
    endtask

    always @(posedge aclk) begin
        scan_byte_t seen;
        scan_byte_t want;
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                pixels[i] = '0;
            end
            plane_cnt = '0;
            row_cnt = '0;
            plane_time = PLANE_TIME_RESET;
            expected_bytes.delete();
        end else begin
            if (cfg_wen && cfg_index < NUM_PLANE_REGS) begin
                plane_time[cfg_index] = cfg_data;
            end
            if (m_valid && m_ready) begin
                seen = '{m_red_bits, m_green_bits, m_blue_bits, m_row_select, m_plane_index,
                         m_blank, m_duration, m_frame_done, m_last};
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Unexpected result transfer: %s", describe(seen));
                    end
                end else begin
                    want = expected_bytes.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("Result mismatch: expected %s", describe(want));
                            $display("                 actual   %s", describe(seen));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_func == FUNC_TICK) begin
                    predict_tick();
                end else if (int'(s_pixel_addr) < STORE_DEPTH) begin
                    pixels[s_pixel_addr] = s_pixel_value;
                end
            end
        end
        pending <= expected_bytes.size();
        errors <= mismatches;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import lps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CFG_PLANE_TIME_0 = 0;
    localparam int CFG_SLOTS = 2 ** CFG_INDEX_W;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_func = FUNC_WRITE;
    logic [PIX_ADDR_W-1:0]  s_pixel_addr = '0;
    logic [PIX_W-1:0]       s_pixel_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [BYTE_W-1:0]      m_red_bits;
    logic [BYTE_W-1:0]      m_green_bits;
    logic [BYTE_W-1:0]      m_blue_bits;
    logic [ROW_SEL_W-1:0]   m_row_select;
    logic [PLANE_W-1:0]     m_plane_index;
    logic                   m_blank;
    logic [DUR_W-1:0]       m_duration;
    logic                   m_frame_done;
    logic                   m_last;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]       cfg_data = '0;
    int                     pending;
    int                     errors;

    bit send_gaps = 1'b1;
    bit recv_stalls = 1'b1;
    int quiet_cycles = 0;

    led_panel_bit_plane_scanner dut (.*);

    scan_checker u_check (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (recv_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic func, input logic [PIX_ADDR_W-1:0] addr,
                             input logic [PIX_W-1:0] value);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_pixel_addr <= addr;
        s_pixel_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Waits until every expected result has been taken and the block has gone quiet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_plane_times(input plane_time_t fill, input bit scatter);
        for (int i = 0; i < CFG_SLOTS; i++) begin
            cfg_wen <= 1'b1;
            cfg_index <= CFG_INDEX_W'(CFG_PLANE_TIME_0 + i);
            cfg_data <= (scatter || i >= NUM_PLANE_REGS) ? DUR_W'($urandom) : fill;
            @(posedge aclk);
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic random_items(input int n);
        logic [PIX_W-1:0] value;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                send_item(FUNC_TICK, PIX_ADDR_W'($urandom), PIX_W'($urandom));
            end else begin
                case ($urandom_range(0, 7))
                    0: value = '0;
                    1: value = '1;
                    default: value = PIX_W'($urandom);
                endcase
                send_item(FUNC_WRITE, PIX_ADDR_W'($urandom), value);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(FUNC_WRITE, 9'd0, 16'hFFFF);
        send_item(FUNC_WRITE, 9'd511, 16'hFFFF);
        send_item(FUNC_WRITE, 9'd31, 16'h07C0);
        send_item(FUNC_WRITE, 9'd272, 16'hF800);
        send_item(FUNC_WRITE, 9'd7, 16'h001F);
        send_item(FUNC_WRITE, 9'd8, 16'h0020);
        for (int i = 0; i < 10; i++) begin
            send_item(FUNC_TICK, '0, '0);
        end
        send_item(FUNC_WRITE, 9'd0, 16'h0000);
        send_item(FUNC_TICK, '1, '1);
        random_items(ITEMS_PER_PHASE);

        settle();
        load_plane_times(16'h0000, 1'b0);
        send_gaps = 1'b0;
        random_items(ITEMS_PER_PHASE);

        settle();
        load_plane_times(16'hFFFF, 1'b0);
        send_gaps = 1'b1;
        recv_stalls = 1'b0;
        random_items(ITEMS_PER_PHASE);

        settle();
        load_plane_times(16'h0000, 1'b1);
        send_gaps = 1'b0;
        random_items(ITEMS_PER_PHASE);

        settle();
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/lps_pkg.sv
rtl/lps_front.sv
rtl/lps_cmd_fifo.sv
rtl/lps_frame_mem.sv
rtl/lps_back.sv
rtl/led_panel_bit_plane_scanner.sv
tb/sv/scan_checker.sv
tb/sv/tb.sv
